### sv/rvff_pkg.sv
// Shared constants and types for the random voxel fill/fade block.
// No dependencies; compiled first.
package rvff_pkg;

  localparam int SIDE_X_DEF = 8;
  localparam int SIDE_Y_DEF = 8;
  localparam int SIDE_Z_DEF = 8;
  localparam int COORD_W    = 3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_DONE
  } rvff_state_t;

  typedef struct packed {
    logic load_start;
    logic step;
    logic init_wr;
    logic rd;
    logic reload;
    logic capture_hit;
    logic capture_miss;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic left_zero;
    logic chk_valid;
    logic hit;
  } dp_status_t;

endpackage

### sv/rvff_if.sv
// Valid/ready channel interfaces for tick transactions and result transactions.
// Depends on rvff_pkg for the coordinate width.
interface rvff_in_if;
  logic                          valid;
  logic                          ready;
  logic [rvff_pkg::COORD_W-1:0]  start_x;
  logic [rvff_pkg::COORD_W-1:0]  start_y;
  logic [rvff_pkg::COORD_W-1:0]  start_z;

  modport source (output valid, output start_x, output start_y, output start_z,
                  input ready);
  modport sink (input valid, input start_x, input start_y, input start_z,
                output ready);
endinterface

interface rvff_out_if;
  logic                          valid;
  logic                          ready;
  logic [rvff_pkg::COORD_W-1:0]  voxel_x;
  logic [rvff_pkg::COORD_W-1:0]  voxel_y;
  logic [rvff_pkg::COORD_W-1:0]  voxel_z;
  logic                          toggled;
  logic                          finished;

  modport source (output valid, output voxel_x, output voxel_y, output voxel_z,
                  output toggled, output finished, input ready);
  modport sink (input valid, input voxel_x, input voxel_y, input voxel_z,
                input toggled, input finished, output ready);
endinterface

### sv/random_voxel_fill_fade.sv
// Random voxel fill/fade for an LED cube. Each tick transaction carries start coordinates;
// the block toggles the first unlit (fill) or lit (fade) voxel found scanning from there,
// x fastest, then y, then z, and returns one result transaction. The voxel map lives in a
// single-port-write, registered-read bitmap memory visited one voxel per cycle. A tick that
// starts a run first sweeps the whole cube to empty or full; the scan then reads voxels until
// a match is found or the whole cube is visited, and the result is handed to the output
// register once that register is free. One tick is in work at a time; a new tick is taken
// while the previous result still waits at the output.
// Depends on rvff_pkg, rvff_if, rvff_ctrl and rvff_datapath.
module random_voxel_fill_fade #(
  parameter int SIDE_X = rvff_pkg::SIDE_X_DEF,
  parameter int SIDE_Y = rvff_pkg::SIDE_Y_DEF,
  parameter int SIDE_Z = rvff_pkg::SIDE_Z_DEF
) (
  input  logic       clk,
  input  logic       rst,
  rvff_in_if.sink    in_item,
  rvff_out_if.source out_item,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data
);

  rvff_pkg::dp_cmd_t    cmd;
  rvff_pkg::dp_status_t st;

  rvff_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_item.valid),
    .in_ready  (in_item.ready),
    .out_valid (out_item.valid),
    .out_ready (out_item.ready),
    .st        (st),
    .cmd       (cmd)
  );

  rvff_datapath #(
    .SIDE_X (SIDE_X),
    .SIDE_Y (SIDE_Y),
    .SIDE_Z (SIDE_Z)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .start_x     (in_item.start_x),
    .start_y     (in_item.start_y),
    .start_z     (in_item.start_z),
    .cmd         (cmd),
    .st          (st),
    .voxel_x     (out_item.voxel_x),
    .voxel_y     (out_item.voxel_y),
    .voxel_z     (out_item.voxel_z),
    .toggled     (out_item.toggled),
    .finished    (out_item.finished)
  );

`ifndef ASSERT_OFF
  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    out_item.valid |-> (out_item.toggled ^ out_item.finished))
    else $error("result is neither toggled nor finished, or both");

  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    !(cmd.init_wr && cmd.capture_hit))
    else $error("init sweep and toggle write collide");

  a_one_tick: assert property (@(posedge clk) disable iff (rst)
    (in_item.valid && in_item.ready) |=> !in_item.ready)
    else $error("second tick taken while one is in work");

  a_chk_follows_rd: assert property (@(posedge clk) disable iff (rst)
    st.chk_valid |-> $past(cmd.rd))
    else $error("check stage valid without a read issued");
`endif

endmodule

### sv/rvff_datapath.sv
// Datapath: voxel bitmap memory, scan position counters, check stage and result registers.
// Depends on rvff_pkg; driven by rvff_ctrl through dp_cmd_t.
module rvff_datapath #(
  parameter int SIDE_X = rvff_pkg::SIDE_X_DEF,
  parameter int SIDE_Y = rvff_pkg::SIDE_Y_DEF,
  parameter int SIDE_Z = rvff_pkg::SIDE_Z_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic                         cfg_wr_data,
  input  logic [rvff_pkg::COORD_W-1:0] start_x,
  input  logic [rvff_pkg::COORD_W-1:0] start_y,
  input  logic [rvff_pkg::COORD_W-1:0] start_z,
  input  rvff_pkg::dp_cmd_t            cmd,
  output rvff_pkg::dp_status_t         st,
  output logic [rvff_pkg::COORD_W-1:0] voxel_x,
  output logic [rvff_pkg::COORD_W-1:0] voxel_y,
  output logic [rvff_pkg::COORD_W-1:0] voxel_z,
  output logic                         toggled,
  output logic                         finished
);

  localparam int CW   = rvff_pkg::COORD_W;
  localparam int XW   = $clog2(SIDE_X);
  localparam int YW   = $clog2(SIDE_Y);
  localparam int ZW   = $clog2(SIDE_Z);
  localparam int AW   = XW + YW + ZW;
  localparam int NVOX = SIDE_X * SIDE_Y * SIDE_Z;
  localparam int LW   = $clog2(NVOX + 1);

  logic          mode;
  logic [XW-1:0] pos_x, nx, chk_x;
  logic [YW-1:0] pos_y, ny, chk_y;
  logic [ZW-1:0] pos_z, nz, chk_z;
  logic [LW-1:0] left;
  logic [CW-1:0] rx, ry, rz;
  logic          wrap_x, wrap_y, wrap_z;

  logic          mem [2**AW];
  logic          rd_data;
  logic          chk_valid;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          mem_wdata;

  logic [CW-1:0] res_x, res_y, res_z;
  logic          res_tog, res_fin;
  logic [CW-1:0] out_x, out_y, out_z;
  logic          out_tog, out_fin;

  // start coordinate reduced modulo side
  always_comb begin
    rx = start_x;
    ry = start_y;
    rz = start_z;
    for (int i = 0; i < 4; i++) begin
      if (rx >= SIDE_X) rx = rx - CW'(SIDE_X);
      if (ry >= SIDE_Y) ry = ry - CW'(SIDE_Y);
      if (rz >= SIDE_Z) rz = rz - CW'(SIDE_Z);
    end
  end

  // x fastest, then y, then z, each wrapping
  always_comb begin
    wrap_x = (pos_x == XW'(SIDE_X - 1));
    wrap_y = (pos_y == YW'(SIDE_Y - 1));
    wrap_z = (pos_z == ZW'(SIDE_Z - 1));
    nx = wrap_x ? '0 : pos_x + XW'(1);
    ny = pos_y;
    nz = pos_z;
    if (wrap_x) begin
      ny = wrap_y ? '0 : pos_y + YW'(1);
      if (wrap_y) begin
        nz = wrap_z ? '0 : pos_z + ZW'(1);
      end
    end
  end

  assign mem_we    = cmd.init_wr | cmd.capture_hit;
  assign mem_waddr = cmd.capture_hit ? {chk_z, chk_y, chk_x} : {pos_z, pos_y, pos_x};
  assign mem_wdata = cmd.capture_hit ? ~mode : mode;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.rd) begin
      rd_data <= mem[{pos_z, pos_y, pos_x}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= 1'b0;
      chk_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mode <= cfg_wr_data;
      end
      chk_valid <= cmd.rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_start) begin
      pos_x <= XW'(rx);
      pos_y <= YW'(ry);
      pos_z <= ZW'(rz);
      left  <= LW'(NVOX);
    end else if (cmd.reload) begin
      left  <= LW'(NVOX);
    end else if (cmd.step) begin
      pos_x <= nx;
      pos_y <= ny;
      pos_z <= nz;
      left  <= left - LW'(1);
    end
    if (cmd.rd) begin
      chk_x <= pos_x;
      chk_y <= pos_y;
      chk_z <= pos_z;
    end
    if (cmd.capture_hit) begin
      res_x   <= CW'(chk_x);
      res_y   <= CW'(chk_y);
      res_z   <= CW'(chk_z);
      res_tog <= 1'b1;
      res_fin <= 1'b0;
    end else if (cmd.capture_miss) begin
      res_x   <= '0;
      res_y   <= '0;
      res_z   <= '0;
      res_tog <= 1'b0;
      res_fin <= 1'b1;
    end
    if (cmd.load_out) begin
      out_x   <= res_x;
      out_y   <= res_y;
      out_z   <= res_z;
      out_tog <= res_tog;
      out_fin <= res_fin;
    end
  end

  assign st.left_zero = (left == '0);
  assign st.chk_valid = chk_valid;
  assign st.hit       = chk_valid && (rd_data == mode);

  assign voxel_x  = out_x;
  assign voxel_y  = out_y;
  assign voxel_z  = out_z;
  assign toggled  = out_tog;
  assign finished = out_fin;

endmodule

### sv/rvff_ctrl.sv
// Controller: sequences cube init sweep, scan, result capture and output handoff.
// Depends on rvff_pkg; commands rvff_datapath.
module rvff_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  rvff_pkg::dp_status_t st,
  output rvff_pkg::dp_cmd_t    cmd
);

  rvff_pkg::rvff_state_t state, state_next;
  logic running, running_next;
  logic out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rvff_pkg::ST_IDLE;
      running   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      running   <= running_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    running_next   = running;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    in_ready       = 1'b0;
    case (state)
      rvff_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_start = 1'b1;
          if (running) begin
            state_next = rvff_pkg::ST_SCAN;
          end else begin
            running_next = 1'b1;
            state_next   = rvff_pkg::ST_INIT;
          end
        end
      end
      rvff_pkg::ST_INIT: begin
        // sweep wraps back to the start voxel
        if (!st.left_zero) begin
          cmd.init_wr = 1'b1;
          cmd.step    = 1'b1;
        end else begin
          cmd.reload = 1'b1;
          state_next = rvff_pkg::ST_SCAN;
        end
      end
      rvff_pkg::ST_SCAN: begin
        if (st.hit) begin
          cmd.capture_hit = 1'b1;
          state_next      = rvff_pkg::ST_DONE;
        end else if (st.left_zero && !st.chk_valid) begin
          cmd.capture_miss = 1'b1;
          running_next     = 1'b0;
          state_next       = rvff_pkg::ST_DONE;
        end else if (!st.left_zero) begin
          cmd.rd   = 1'b1;
          cmd.step = 1'b1;
        end
      end
      rvff_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = rvff_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rvff_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
